// File: hdl/mcse_pkg.sv
// types, constants and helpers for the memory card sector exchange
// used by mcse_engine and memory_card_sector_exchange; no dependencies
package mcse_pkg;

  localparam int SECTOR_BYTES = 128;
  localparam int ADDR_BITS    = 10;

  localparam logic [1:0] ACT_START_READ  = 2'd0;
  localparam logic [1:0] ACT_START_WRITE = 2'd1;
  localparam logic [1:0] ACT_EXCHANGE    = 2'd2;
  localparam logic [1:0] ACT_RESERVED    = 2'd3;

  localparam logic [7:0] CMD_BASE   = 8'h81;
  localparam logic [7:0] CMD_READ   = 8'h52;
  localparam logic [7:0] CMD_WRITE  = 8'h57;
  localparam logic [7:0] MARK_5A    = 8'h5a;
  localparam logic [7:0] MARK_5D    = 8'h5d;
  localparam logic [7:0] MARK_5C    = 8'h5c;
  localparam logic [7:0] MARK_END   = 8'h47;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_IDLE = 2'd3
  } status_e;

  typedef enum logic [18:0] {
    PH_IDLE  = 19'h00001,
    PH_MODE  = 19'h00002,
    PH_FLAG  = 19'h00004,
    PH_M5A   = 19'h00008,
    PH_M5D   = 19'h00010,
    PH_AHI   = 19'h00020,
    PH_RLO   = 19'h00040,
    PH_R5C   = 19'h00080,
    PH_R5D   = 19'h00100,
    PH_RHI   = 19'h00200,
    PH_RLOE  = 19'h00400,
    PH_RDATA = 19'h00800,
    PH_RCHK  = 19'h01000,
    PH_END   = 19'h02000,
    PH_WDATA = 19'h04000,
    PH_WCS   = 19'h08000,
    PH_WACK  = 19'h10000,
    PH_W5C   = 19'h20000,
    PH_W5D   = 19'h40000
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic       card_slot;
    logic [3:0] floor;
    logic [9:0] sector;
    logic [7:0] rx_byte;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       slot_select;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       write_taken;
    logic [7:0] card_flag;
    logic [1:0] status;
  } out_item_t;

  function automatic logic [7:0] addr_hi(input logic [ADDR_BITS-1:0] s);
    logic [15:0] w;
    w = 16'(s);
    return w[15:8];
  endfunction

  function automatic logic [7:0] addr_lo(input logic [ADDR_BITS-1:0] s);
    logic [15:0] w;
    w = 16'(s);
    return w[7:0];
  endfunction

endpackage

// File: hdl/mcse_engine.sv
// transfer state registers and the per-beat sequencing and checking logic
// depends on mcse_pkg
module mcse_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  mcse_pkg::in_item_t   item_i,
  output mcse_pkg::out_item_t  res_o
);

  mcse_pkg::phase_e              phase_q, phase_d;
  logic [7:0]                    byte_count_q, byte_count_d;
  logic [7:0]                    running_xor_q, running_xor_d;
  logic [7:0]                    flag_copy_q, flag_copy_d;
  logic [mcse_pkg::ADDR_BITS-1:0] held_sector_q, held_sector_d;
  logic                          is_write_q, is_write_d;
  logic                          held_slot_q, held_slot_d;

  logic [15:0]       sec16;
  logic [7:0]        count_inc;
  logic [7:0]        tx;
  logic [7:0]        rd;
  logic              rv, wt, ok;
  mcse_pkg::status_e st;

  always_comb begin
    phase_d       = phase_q;
    byte_count_d  = byte_count_q;
    running_xor_d = running_xor_q;
    flag_copy_d   = flag_copy_q;
    held_sector_d = held_sector_q;
    is_write_d    = is_write_q;
    held_slot_d   = held_slot_q;
    sec16         = 16'(item_i.sector);
    count_inc     = byte_count_q + 8'd1;
    tx            = 8'h00;
    rd            = 8'h00;
    rv            = 1'b0;
    wt            = 1'b0;
    ok            = 1'b1;
    st            = mcse_pkg::ST_BUSY;

    if (item_i.action == mcse_pkg::ACT_START_READ ||
        item_i.action == mcse_pkg::ACT_START_WRITE) begin
      is_write_d    = (item_i.action == mcse_pkg::ACT_START_WRITE);
      held_slot_d   = item_i.card_slot;
      held_sector_d = sec16[mcse_pkg::ADDR_BITS-1:0];
      byte_count_d  = 8'd0;
      flag_copy_d   = 8'd0;
      running_xor_d = mcse_pkg::addr_lo(held_sector_d) ^ mcse_pkg::addr_hi(held_sector_d);
      // floors above 7 count down from the base command
      tx = (item_i.floor > 4'd7) ? (mcse_pkg::CMD_BASE - {4'b0, item_i.floor})
                                 : (mcse_pkg::CMD_BASE + {4'b0, item_i.floor});
      phase_d = mcse_pkg::PH_MODE;
    end else if (item_i.action == mcse_pkg::ACT_RESERVED ||
                 phase_q == mcse_pkg::PH_IDLE) begin
      st = (phase_q == mcse_pkg::PH_IDLE) ? mcse_pkg::ST_IDLE : mcse_pkg::ST_BUSY;
    end else begin
      unique case (phase_q)
        mcse_pkg::PH_MODE: begin
          tx      = is_write_q ? mcse_pkg::CMD_WRITE : mcse_pkg::CMD_READ;
          phase_d = mcse_pkg::PH_FLAG;
        end
        mcse_pkg::PH_FLAG: begin
          flag_copy_d = item_i.rx_byte;
          phase_d     = mcse_pkg::PH_M5A;
        end
        mcse_pkg::PH_M5A: begin
          ok      = (item_i.rx_byte == mcse_pkg::MARK_5A);
          phase_d = mcse_pkg::PH_M5D;
        end
        mcse_pkg::PH_M5D: begin
          ok      = (item_i.rx_byte == mcse_pkg::MARK_5D);
          tx      = mcse_pkg::addr_hi(held_sector_q);
          phase_d = mcse_pkg::PH_AHI;
        end
        mcse_pkg::PH_AHI: begin
          tx      = mcse_pkg::addr_lo(held_sector_q);
          phase_d = is_write_q ? mcse_pkg::PH_WDATA : mcse_pkg::PH_RLO;
        end
        mcse_pkg::PH_RLO: phase_d = mcse_pkg::PH_R5C;
        mcse_pkg::PH_R5C: begin
          ok      = (item_i.rx_byte == mcse_pkg::MARK_5C);
          phase_d = mcse_pkg::PH_R5D;
        end
        mcse_pkg::PH_R5D: begin
          ok      = (item_i.rx_byte == mcse_pkg::MARK_5D);
          phase_d = mcse_pkg::PH_RHI;
        end
        mcse_pkg::PH_RHI: begin
          ok      = (item_i.rx_byte == mcse_pkg::addr_hi(held_sector_q));
          phase_d = mcse_pkg::PH_RLOE;
        end
        mcse_pkg::PH_RLOE: begin
          ok      = (item_i.rx_byte == mcse_pkg::addr_lo(held_sector_q));
          phase_d = mcse_pkg::PH_RDATA;
        end
        mcse_pkg::PH_RDATA: begin
          rd            = item_i.rx_byte;
          rv            = 1'b1;
          running_xor_d = running_xor_q ^ item_i.rx_byte;
          byte_count_d  = count_inc;
          if (count_inc == 8'(mcse_pkg::SECTOR_BYTES)) phase_d = mcse_pkg::PH_RCHK;
        end
        mcse_pkg::PH_RCHK: begin
          ok      = (item_i.rx_byte == running_xor_q);
          phase_d = mcse_pkg::PH_END;
        end
        mcse_pkg::PH_WDATA: begin
          tx            = item_i.write_byte;
          wt            = 1'b1;
          running_xor_d = running_xor_q ^ item_i.write_byte;
          byte_count_d  = count_inc;
          if (count_inc == 8'(mcse_pkg::SECTOR_BYTES)) phase_d = mcse_pkg::PH_WCS;
        end
        mcse_pkg::PH_WCS: begin
          tx      = running_xor_q;
          phase_d = mcse_pkg::PH_WACK;
        end
        mcse_pkg::PH_WACK: phase_d = mcse_pkg::PH_W5C;
        mcse_pkg::PH_W5C: begin
          ok      = (item_i.rx_byte == mcse_pkg::MARK_5C);
          phase_d = mcse_pkg::PH_W5D;
        end
        // the card's marker here is not checked on writes
        mcse_pkg::PH_W5D: phase_d = mcse_pkg::PH_END;
        mcse_pkg::PH_END: begin
          ok = (item_i.rx_byte == mcse_pkg::MARK_END);
          if (ok) begin
            st      = mcse_pkg::ST_DONE;
            phase_d = mcse_pkg::PH_IDLE;
          end
        end
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        st      = mcse_pkg::ST_ERR;
        tx      = 8'h00;
        phase_d = mcse_pkg::PH_IDLE;
      end
    end

    res_o.tx_byte     = tx;
    res_o.slot_select = held_slot_d;
    res_o.read_byte   = rd;
    res_o.read_valid  = rv;
    res_o.write_taken = wt;
    res_o.card_flag   = flag_copy_d;
    res_o.status      = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= mcse_pkg::PH_IDLE;
      byte_count_q  <= 8'd0;
      running_xor_q <= 8'd0;
      flag_copy_q   <= 8'd0;
      held_sector_q <= '0;
      is_write_q    <= 1'b0;
      held_slot_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q       <= phase_d;
      byte_count_q  <= byte_count_d;
      running_xor_q <= running_xor_d;
      flag_copy_q   <= flag_copy_d;
      held_sector_q <= held_sector_d;
      is_write_q    <= is_write_d;
      held_slot_q   <= held_slot_d;
    end
  end

  a_err_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.status == mcse_pkg::ST_ERR |=> phase_q == mcse_pkg::PH_IDLE)
    else $error("error beat did not return to idle");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.status == mcse_pkg::ST_DONE |=> phase_q == mcse_pkg::PH_IDLE)
    else $error("done beat did not return to idle");

  a_read_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.read_valid |-> !is_write_q && !res_o.write_taken)
    else $error("payload byte passed on during a write");

  a_write_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.write_taken |-> is_write_q)
    else $error("payload byte consumed during a read");

  a_hold_without_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(byte_count_q))
    else $error("transfer state moved without a beat");

endmodule

// File: hdl/memory_card_sector_exchange.sv
// Host side sequencer for one memory card sector read or write, one byte per beat.
//
// Input channel (in_valid_i / in_stall_o / in_i): each beat is either a start
// (read or write) carrying slot, floor and sector, or a byte exchange carrying
// the byte the card returned last time and, in a write's data phase, the next
// payload byte. Output channel (out_valid_o / out_stall_i / out_o): exactly one
// result beat per input beat, in order, with the byte to send next, the slot,
// any received payload byte, the card's flag byte and a status code.
// An accepted input beat passes through an input register, then the sequencing
// logic, then the result register. Throughput is one beat per cycle while
// out_stall_i does not hold the result register full; mcse_engine updates its state on every fired beat.
// When out_stall_i holds the result register full, in_stall_o rises while the
// input register is also full; a stalled result stays stable. Reset clears
// both registers' valid flags and returns the transfer to idle.
// depends on mcse_pkg and mcse_engine
module memory_card_sector_exchange (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mcse_pkg::in_item_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mcse_pkg::out_item_t  out_o
);

  logic                in_valid_q;
  mcse_pkg::in_item_t  in_q;
  logic                out_valid_q;
  mcse_pkg::out_item_t out_q;
  mcse_pkg::out_item_t res;
  logic                out_free;
  logic                fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  mcse_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= fire;
    end
  end

  // payload registers load on a taken beat only
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_i;
    if (fire) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: tb/memory_card_sector_exchange_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for memory_card_sector_exchange: directed and random sector
// transfers with a scoreboard class that predicts every result beat
// depends on mcse_pkg and memory_card_sector_exchange
module memory_card_sector_exchange_tb;
  import mcse_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int TARGET_BEATS    = 1550;
  localparam int HOLD_CYCLES     = 300;

  class exchange_tracker;
    phase_e     phase;
    logic [7:0] byte_cnt;
    logic [7:0] run_xor;
    logic [7:0] flag_copy;
    logic [9:0] held_sector;
    logic       is_write;
    logic       held_slot;
    out_item_t  pending_replies[$];
    int         errors;

    function new();
      phase       = PH_IDLE;
      byte_cnt    = '0;
      run_xor     = '0;
      flag_copy   = '0;
      held_sector = '0;
      is_write    = 1'b0;
      held_slot   = 1'b0;
      errors      = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // advance the transfer by one accepted input beat and queue its result
    function void take_beat(in_item_t it);
      out_item_t  r;
      logic       ok;
      logic [7:0] hi;
      logic [7:0] lo;
      r = '0;
      r.status = ST_BUSY;
      ok = 1'b1;
      if (it.action == ACT_START_READ || it.action == ACT_START_WRITE) begin
        is_write    = (it.action == ACT_START_WRITE);
        held_slot   = it.card_slot;
        held_sector = it.sector;
        byte_cnt    = '0;
        flag_copy   = '0;
        run_xor     = it.sector[7:0] ^ {6'd0, it.sector[9:8]};
        r.tx_byte   = (it.floor > 4'd7) ? CMD_BASE - 8'(it.floor) : CMD_BASE + 8'(it.floor);
        phase       = PH_MODE;
      end else if (it.action == ACT_RESERVED || phase == PH_IDLE) begin
        r.status = (phase == PH_IDLE) ? ST_IDLE : ST_BUSY;
      end else begin
        hi = {6'd0, held_sector[9:8]};
        lo = held_sector[7:0];
        case (phase)
          PH_MODE: begin
            r.tx_byte = is_write ? CMD_WRITE : CMD_READ;
            phase = PH_FLAG;
          end
          PH_FLAG: begin
            flag_copy = it.rx_byte;
            phase = PH_M5A;
          end
          PH_M5A: begin
            ok = (it.rx_byte == MARK_5A);
            phase = PH_M5D;
          end
          PH_M5D: begin
            ok = (it.rx_byte == MARK_5D);
            r.tx_byte = hi;
            phase = PH_AHI;
          end
          PH_AHI: begin
            r.tx_byte = lo;
            phase = is_write ? PH_WDATA : PH_RLO;
          end
          PH_RLO: phase = PH_R5C;
          PH_R5C: begin
            ok = (it.rx_byte == MARK_5C);
            phase = PH_R5D;
          end
          PH_R5D: begin
            ok = (it.rx_byte == MARK_5D);
            phase = PH_RHI;
          end
          PH_RHI: begin
            ok = (it.rx_byte == hi);
            phase = PH_RLOE;
          end
          PH_RLOE: begin
            ok = (it.rx_byte == lo);
            phase = PH_RDATA;
          end
          PH_RDATA: begin
            r.read_byte  = it.rx_byte;
            r.read_valid = 1'b1;
            run_xor      = run_xor ^ it.rx_byte;
            byte_cnt     = byte_cnt + 8'd1;
            if (byte_cnt == 8'(SECTOR_BYTES)) phase = PH_RCHK;
          end
          PH_RCHK: begin
            ok = (it.rx_byte == run_xor);
            phase = PH_END;
          end
          PH_WDATA: begin
            r.tx_byte     = it.write_byte;
            r.write_taken = 1'b1;
            run_xor       = run_xor ^ it.write_byte;
            byte_cnt      = byte_cnt + 8'd1;
            if (byte_cnt == 8'(SECTOR_BYTES)) phase = PH_WCS;
          end
          PH_WCS: begin
            r.tx_byte = run_xor;
            phase = PH_WACK;
          end
          PH_WACK: phase = PH_W5C;
          PH_W5C: begin
            ok = (it.rx_byte == MARK_5C);
            phase = PH_W5D;
          end
          // card reply after the write 0x5c marker goes unchecked
          PH_W5D: phase = PH_END;
          PH_END: begin
            ok = (it.rx_byte == MARK_END);
            if (ok) begin
              r.status = ST_DONE;
              phase = PH_IDLE;
            end
          end
          default: ok = 1'b0;
        endcase
        if (!ok) begin
          r.status  = ST_ERR;
          r.tx_byte = '0;
          phase     = PH_IDLE;
        end
      end
      r.slot_select = held_slot;
      r.card_flag   = flag_copy;
      pending_replies.push_back(r);
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_reply(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t result beat with nothing expected: actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      field_check("tx_byte", want.tx_byte, got.tx_byte);
      field_check("slot_select", 8'(want.slot_select), 8'(got.slot_select));
      field_check("read_byte", want.read_byte, got.read_byte);
      field_check("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      field_check("write_taken", 8'(want.write_taken), 8'(got.write_taken));
      field_check("card_flag", want.card_flag, got.card_flag);
      field_check("status", 8'(want.status), 8'(got.status));
    endfunction

    function void report_leftovers();
      foreach (pending_replies[i]) begin
        $display("%0t result never arrived: expected %h, actual none", $time,
                 pending_replies[i]);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int beats_sent = 0;

  exchange_tracker tracker;

  always #5 clk = ~clk;

  memory_card_sector_exchange uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  initial tracker = new();

  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) tracker.take_beat(in_data);
      if (out_valid && !out_stall) tracker.match_reply(out_data);
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : receiver
    wait (rst_ni);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int stale;
    stale = 0;
    wait (rst_ni);
    while (stale < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stale = 0;
      else stale++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_item_t random_fields();
    in_item_t it;
    it.action     = 2'($urandom_range(0, 3));
    it.card_slot  = 1'($urandom);
    it.floor      = 4'($urandom);
    it.sector     = 10'($urandom);
    it.rx_byte    = 8'($urandom);
    it.write_byte = 8'($urandom);
    return it;
  endfunction

  // offer one beat, hold it until taken, then maybe leave a gap
  task automatic send_beat(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.action != ACT_RESERVED) beats_sent++;
    if (idle_on && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic exchange(input logic [7:0] rx);
    in_item_t it;
    it = random_fields();
    it.action  = ACT_EXCHANGE;
    it.rx_byte = rx;
    send_beat(it);
  endtask

  task automatic reserved_beat();
    in_item_t it;
    it = random_fields();
    it.action = ACT_RESERVED;
    send_beat(it);
  endtask

  task automatic start_transfer(input logic wr, input logic slot, input logic [3:0] flr,
                                input logic [9:0] sec);
    in_item_t it;
    it = random_fields();
    it.action    = wr ? ACT_START_WRITE : ACT_START_READ;
    it.card_slot = slot;
    it.floor     = flr;
    it.sector    = sec;
    send_beat(it);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // one transfer with well-formed card replies; optionally one checked reply is
  // corrupted, or the transfer is cut short so the next start lands while busy
  task automatic run_transfer(input logic wr, input int cut_len, input bit corrupt);
    logic [9:0] sec;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] sum;
    logic [7:0] d;
    logic [7:0] script[$];
    int         checked[$];
    int         bad;
    case ($urandom_range(0, 5))
      0:       sec = '0;
      1:       sec = '1;
      default: sec = 10'($urandom);
    endcase
    hi  = {6'd0, sec[9:8]};
    lo  = sec[7:0];
    sum = hi ^ lo;
    script  = {8'($urandom), 8'($urandom), MARK_5A, MARK_5D, 8'($urandom)};
    checked = {2, 3};
    if (!wr) begin
      script  = {script, 8'($urandom), MARK_5C, MARK_5D, hi, lo};
      checked = {checked, 6, 7, 8, 9};
      repeat (SECTOR_BYTES) begin
        d = 8'($urandom);
        sum ^= d;
        script.push_back(d);
      end
      checked.push_back(script.size());
      script.push_back(sum);
    end else begin
      repeat (SECTOR_BYTES + 2) script.push_back(8'($urandom));
      checked.push_back(script.size());
      script.push_back(MARK_5C);
      script.push_back(8'($urandom));
    end
    checked.push_back(script.size());
    script.push_back(MARK_END);

    bad = corrupt ? checked[$urandom_range(0, checked.size() - 1)] : -1;
    if (cut_len < 0 || cut_len > script.size()) cut_len = script.size();
    if (bad >= 0) cut_len = bad + 1;

    start_transfer(wr, 1'($urandom), 4'($urandom), sec);
    for (int i = 0; i < cut_len; i++) begin
      if ($urandom_range(0, 39) == 0) reserved_beat();
      exchange((i == bad) ? script[i] ^ 8'($urandom_range(1, 255)) : script[i]);
    end
  endtask

  initial begin : stimulus
    in_item_t it;
    bit       hold_done;
    bit       drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // idle block: exchange with every field high, then a reserved beat
    it = '1;
    it.action = ACT_EXCHANGE;
    send_beat(it);
    it = '0;
    it.action = ACT_RESERVED;
    send_beat(it);
    // floor extremes on the command byte; second start aborts the first
    start_transfer(1'b0, 1'b0, 4'd0, 10'd0);
    start_transfer(1'b1, 1'b1, 4'd15, 10'd1023);
    reserved_beat();
    exchange(8'h00);
    exchange(8'hff);
    exchange(8'h5b);
    start_transfer(1'b0, 1'b1, 4'd7, 10'h2aa);
    exchange(8'h00);
    exchange(8'h00);
    exchange(MARK_5A);
    exchange(MARK_5C);
    // bad echoed high address byte
    start_transfer(1'b0, 1'b0, 4'd8, 10'h155);
    exchange(8'h33);
    exchange(8'h80);
    exchange(MARK_5A);
    exchange(MARK_5D);
    exchange(8'h00);
    exchange(8'h00);
    exchange(MARK_5C);
    exchange(MARK_5D);
    exchange(8'h02);

    while (beats_sent < TARGET_BEATS) begin
      if (!hold_done && beats_sent > 450) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && beats_sent > 900) begin
        in_valid <= 1'b0;
        wait_for_drain();
        drain_done = 1'b1;
      end
      if (beats_sent > 1250) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       repeat ($urandom_range(1, 6)) send_beat(random_fields());
        1:       run_transfer(1'($urandom), -1, 1'b1);
        2:       run_transfer(1'($urandom), $urandom_range(0, 137), 1'b0);
        default: run_transfer(1'($urandom), -1, 1'b0);
      endcase
    end

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (8) @(posedge clk);
    tracker.report_leftovers();
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mcse_pkg.sv
hdl/mcse_engine.sv
hdl/memory_card_sector_exchange.sv
tb/memory_card_sector_exchange_tb.sv
